### rtl/odo_pkg.sv
// Package for differential-drive wheel odometry.
// Widths, register indexes, CORDIC constants, arctan table and the
// command/status structs shared by controller and datapath. No dependencies.
`default_nettype none

package odo_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CNT_W      = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 32;
    localparam int ANG_W      = 32;
    localparam int DELTA_W    = 18;
    localparam int SUM_W      = 19;
    localparam int WIDE_W     = 34;
    localparam int CORDIC_W   = 34;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 79;
    localparam int ROUND_BIT  = 46;
    localparam int RES_LSB    = 47;
    localparam int ATAN_IDX_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE = 2'd1;

    localparam logic [CFG_W-1:0] DIST_RESET  = 24'd1271040;
    localparam logic [CFG_W-1:0] ANGLE_RESET = 24'd525970;

    localparam logic signed [WIDE_W-1:0]   UNWRAP_LIMIT = 34'sd30000;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic [ANG_W-1:0]           HALF_TURN    = 32'h8000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DELTA,
        OP_MSUM,
        OP_MTURN,
        OP_HEAD,
        OP_CINIT,
        OP_CSTEP,
        OP_PLO,
        OP_PHI,
        OP_PACC,
        OP_PADD
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic                    axis;
        logic [ATAN_IDX_W-1:0]   step;
        logic                    take_in;
        logic                    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic have_prev;
    } dp_stat_t;

    function automatic logic [ANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] k);
        logic [ANG_W-1:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/odo_if.sv
// Valid/ready channel interfaces for encoder samples and pose items.
// Depends on odo_pkg.
`default_nettype none

interface odo_in_if import odo_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;

    modport source (output valid, output left_count, output right_count, input ready);
    modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

interface odo_out_if import odo_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0]        heading;
    logic                    primed;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output primed, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input primed, output ready);
endinterface

`default_nettype wire

### rtl/diff_drive_wheel_odometry_top.sv
// Top level of differential-drive wheel odometry.
// Depends on odo_pkg, odo_if, odo_ctrl and odo_dp.
//
//   port      dir   payload                               handshake
//   sample    in    left_count, right_count               valid/ready
//   pose      out   pos_x, pos_y, heading, primed          valid/ready
//   cfg_*     in    cfg_index, cfg_data (24b)             cfg_we, no stall
//
// An updating sample is held from acceptance to re-acceptance by the
// one-step-per-cycle CORDIC and the shared 32x32 multiplier. A priming
// sample skips both and goes from the delta straight to the pose load.
// Reset restores both gains and clears the internal pose and the previous counts.
// A new sample is taken while the last pose waits; the block stalls only
// when a second pose is ready before the first was taken.
`default_nettype none

module diff_drive_wheel_odometry_top import odo_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    odo_in_if.sink               sample,
    odo_out_if.source            pose
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    odo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (pose.valid),
        .out_ready (pose.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    odo_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_count  (sample.left_count),
        .right_count (sample.right_count),
        .cmd         (cmd),
        .stat        (stat),
        .pos_x       (pose.pos_x),
        .pos_y       (pose.pos_y),
        .heading     (pose.heading),
        .primed      (pose.primed)
    );

endmodule

`default_nettype wire

### rtl/odo_ctrl.sv
// Odometry controller: one-hot sequencer issuing datapath commands,
// CORDIC step counter and output valid. Depends on odo_pkg.
`default_nettype none

module odo_ctrl import odo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DELTA = 12'b0000_0000_0010,
        S_MSUM  = 12'b0000_0000_0100,
        S_MTURN = 12'b0000_0000_1000,
        S_HEAD  = 12'b0000_0001_0000,
        S_CINIT = 12'b0000_0010_0000,
        S_CSTEP = 12'b0000_0100_0000,
        S_PLO   = 12'b0000_1000_0000,
        S_PHI   = 12'b0001_0000_0000,
        S_PACC  = 12'b0010_0000_0000,
        S_PADD  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.axis       = axis_reg;
        cmd.step       = ATAN_IDX_W'(step_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_DELTA;
                end
            end
            S_DELTA:
            begin
                cmd.op     = OP_DELTA;
                state_next = stat.have_prev ? S_MSUM : S_DONE;
            end
            S_MSUM:
            begin
                cmd.op     = OP_MSUM;
                state_next = S_MTURN;
            end
            S_MTURN:
            begin
                cmd.op     = OP_MTURN;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cmd.op     = OP_HEAD;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.op     = OP_CINIT;
                step_next  = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.op = OP_CSTEP;
                if (step_reg == STEP_LAST)
                begin
                    axis_next  = 1'b0;
                    state_next = S_PLO;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PLO:
            begin
                cmd.op     = OP_PLO;
                state_next = S_PHI;
            end
            S_PHI:
            begin
                cmd.op     = OP_PHI;
                state_next = S_PACC;
            end
            S_PACC:
            begin
                cmd.op     = OP_PACC;
                state_next = S_PADD;
            end
            S_PADD:
            begin
                cmd.op = OP_PADD;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = S_PLO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/odo_dp.sv
// Odometry datapath: config registers, unwrap, shared 32x32 multiplier,
// iterative CORDIC, rounding accumulator and pose registers. Depends on odo_pkg.
`default_nettype none

module odo_dp import odo_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic [CNT_W-1:0]        left_count,
    input  logic [CNT_W-1:0]        right_count,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic [ANG_W-1:0]        heading,
    output logic                    primed
);

    localparam logic [CNT_W:0] ONE_EXT = 17'd1;
    localparam logic [CNT_W-1:0] CNT_MASK = (COUNTER_BITS >= CNT_W) ? '1 :
        CNT_W'((ONE_EXT << COUNTER_BITS) - ONE_EXT);
    localparam logic signed [WIDE_W-1:0] PERIOD = 34'sd1 <<< COUNTER_BITS;
    localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1) << ROUND_BIT;

    logic [CFG_W-1:0]           dist_reg, angle_reg;
    logic [CNT_W-1:0]           cur_left_reg, cur_right_reg;
    logic [CNT_W-1:0]           prev_left_reg, prev_right_reg;
    logic                       have_prev_reg, primed_reg;
    logic signed [DELTA_W-1:0]  dl_reg, dr_reg;
    logic                       sum_neg_reg, flip_reg;
    logic [PROD_W-1:0]          prod_reg, ms_reg;
    logic [ANG_W-1:0]           head_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [POS_W-1:0]           px_reg, py_reg;
    logic [POS_W-1:0]           out_x_reg, out_y_reg;
    logic [ANG_W-1:0]           out_head_reg;
    logic                       out_primed_reg;

    logic signed [SUM_W-1:0]    sum_s, diff_s, sum_mag;
    logic signed [CORDIC_W-1:0] trig, trig_mag, xs, ys;
    logic                       inc_neg;
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [PROD_W-1:0]          mul_prod;
    logic [POS_W-1:0]           res, inc;
    logic [ANG_W-1:0]           folded;
    logic [CORDIC_W-1:0]        atan_ext;

    function automatic logic signed [DELTA_W-1:0] unwrap(input logic [CNT_W-1:0] now,
                                                         input logic [CNT_W-1:0] prev);
        logic signed [WIDE_W-1:0] d;
        d = signed'(WIDE_W'(now)) - signed'(WIDE_W'(prev));
        if (d > UNWRAP_LIMIT)
            d = d - PERIOD;
        if (d < -UNWRAP_LIMIT)
            d = d + PERIOD;
        return d[DELTA_W-1:0];
    endfunction

    always_comb
    begin
        sum_s    = SUM_W'(dl_reg) + SUM_W'(dr_reg);
        diff_s   = SUM_W'(dr_reg) - SUM_W'(dl_reg);
        sum_mag  = sum_s[SUM_W-1] ? -sum_s : sum_s;
        trig     = cmd.axis ? cy_reg : cx_reg;
        trig_mag = trig[CORDIC_W-1] ? -trig : trig;
        inc_neg  = sum_neg_reg ^ trig[CORDIC_W-1] ^ flip_reg;
        res      = acc_reg[RES_LSB +: POS_W];
        inc      = inc_neg ? -res : res;
        xs       = cx_reg >>> cmd.step;
        ys       = cy_reg >>> cmd.step;
        atan_ext = CORDIC_W'(atan_lut(cmd.step));
        folded   = (head_reg[ANG_W-1 -: 2] == 2'b01 || head_reg[ANG_W-1 -: 2] == 2'b10) ?
                   (head_reg ^ HALF_TURN) : head_reg;
        unique case (cmd.op)
            OP_MSUM:
            begin
                mul_a = MUL_W'(unsigned'(sum_mag));
                mul_b = MUL_W'(dist_reg);
            end
            OP_MTURN:
            begin
                mul_a = MUL_W'(diff_s);
                mul_b = MUL_W'(angle_reg);
            end
            OP_PLO:
            begin
                mul_a = ms_reg[MUL_W-1:0];
                mul_b = trig_mag[MUL_W-1:0];
            end
            OP_PHI:
            begin
                mul_a = ms_reg[PROD_W-1:MUL_W];
                mul_b = trig_mag[MUL_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg       <= DIST_RESET;
            angle_reg      <= ANGLE_RESET;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            have_prev_reg  <= 1'b0;
            primed_reg     <= 1'b0;
            head_reg       <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIST:  dist_reg  <= cfg_data;
                    CFG_ANGLE: angle_reg <= cfg_data;
                    default:   ;
                endcase
            end
            unique case (cmd.op)
                OP_DELTA:
                begin
                    prev_left_reg  <= cur_left_reg;
                    prev_right_reg <= cur_right_reg;
                    have_prev_reg  <= 1'b1;
                    primed_reg     <= have_prev_reg;
                end
                OP_HEAD:
                begin
                    head_reg <= head_reg + prod_reg[ANG_W-1:0];
                end
                OP_PADD:
                begin
                    if (cmd.axis)
                        py_reg <= py_reg + inc;
                    else
                        px_reg <= px_reg + inc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        if (cmd.take_in)
        begin
            cur_left_reg  <= left_count & CNT_MASK;
            cur_right_reg <= right_count & CNT_MASK;
        end
        if (cmd.load_out)
        begin
            out_x_reg      <= px_reg;
            out_y_reg      <= py_reg;
            out_head_reg   <= head_reg;
            out_primed_reg <= primed_reg;
        end
        unique case (cmd.op)
            OP_DELTA:
            begin
                dl_reg <= unwrap(cur_left_reg, prev_left_reg);
                dr_reg <= unwrap(cur_right_reg, prev_right_reg);
            end
            OP_MSUM:
            begin
                sum_neg_reg <= sum_s[SUM_W-1];
            end
            OP_MTURN:
            begin
                ms_reg <= prod_reg;
            end
            OP_CINIT:
            begin
                flip_reg <= (folded != head_reg);
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
                cz_reg   <= CORDIC_W'(signed'(folded));
            end
            OP_CSTEP:
            begin
                if (!cz_reg[CORDIC_W-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - signed'(atan_ext);
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + signed'(atan_ext);
                end
            end
            OP_PHI:
            begin
                acc_reg <= ACC_W'(prod_reg) + ROUND_ADD;
            end
            OP_PACC:
            begin
                acc_reg <= acc_reg + ACC_W'({prod_reg, {MUL_W{1'b0}}});
            end
            default: ;
        endcase
    end

    assign stat.have_prev = have_prev_reg;
    assign pos_x   = signed'(out_x_reg);
    assign pos_y   = signed'(out_y_reg);
    assign heading = out_head_reg;
    assign primed  = out_primed_reg;

endmodule

`default_nettype wire
